@@ design/assert_macros.svh @@
// Assertion helpers shared by the blur block.
// Both expect signals named clk and rst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

@@ design/gbr_pkg.sv @@
// ----------------------------------------------------------------------------
// gbr_pkg
// Shared constants, pixel and control types of the 3x3 RGBA blur block.
// ----------------------------------------------------------------------------
package gbr_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int CHANNEL_BITS = 16;
  localparam int NUM_CHANNELS = 4;

  localparam int CHAN_W       = 16;
  localparam int PIX_W        = NUM_CHANNELS * CHAN_W;
  localparam int PADDED_DEPTH = MAX_WIDTH + 2;
  localparam int ADDR_W       = $clog2(PADDED_DEPTH);
  localparam int POS_W        = $clog2(PADDED_DEPTH + 1);
  localparam int ROW_W        = 17;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 16;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 16;
  localparam int SUM_W        = CHANNEL_BITS + 4;
  localparam int WIN_TAPS     = 6;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(1024);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(1024);

  localparam logic [CHAN_W-1:0] CHAN_MASK = CHAN_W'((1 << CHANNEL_BITS) - 1);

  typedef logic [NUM_CHANNELS-1:0][CHAN_W-1:0] pix_t;

  // Position of one accepted word, as seen by the filter stage.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              produce;
    logic              last;
  } pos_t;

  // Write-back to the line RAM: entry holds {upper row, middle row}.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [2*PIX_W-1:0] data;
  } ram_wr_t;

endpackage

@@ design/gbr_if.sv @@
// ----------------------------------------------------------------------------
// gbr_if
// Handshake channels of the blur block: pixel in, pixel out, register write.
// ----------------------------------------------------------------------------
interface gbr_pix_in_if;
  logic                      valid;
  logic                      ready;
  logic [gbr_pkg::CHAN_W-1:0] in_red;
  logic [gbr_pkg::CHAN_W-1:0] in_green;
  logic [gbr_pkg::CHAN_W-1:0] in_blue;
  logic [gbr_pkg::CHAN_W-1:0] in_alpha;

  modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
  modport sink (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface gbr_pix_out_if;
  logic                      valid;
  logic                      ready;
  logic [gbr_pkg::CHAN_W-1:0] out_red;
  logic [gbr_pkg::CHAN_W-1:0] out_green;
  logic [gbr_pkg::CHAN_W-1:0] out_blue;
  logic [gbr_pkg::CHAN_W-1:0] out_alpha;
  logic                      frame_last;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_last,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, frame_last,
                output ready);
endinterface

interface gbr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gbr_pkg::CFG_IDX_W-1:0]  index;
  logic [gbr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/gbr_line_ram.sv @@
// ----------------------------------------------------------------------------
// gbr_line_ram
// Simple dual-port RAM: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gbr_line_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1026
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/gbr_pos.sv @@
// ----------------------------------------------------------------------------
// gbr_pos
// Size registers and padded row/column counters; tags each word with its
// line RAM address, whether it yields an output and whether it ends a frame.
// ----------------------------------------------------------------------------
module gbr_pos (
  input  logic           clk,
  input  logic           rst_n,
  gbr_cfg_if.sink        cfg,
  input  logic           in_acc,
  output gbr_pkg::pos_t  pos
);
  import gbr_pkg::*;

  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;
  logic [POS_W-1:0]        col_r, col_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;

  logic [POS_W-1:0] w_eff, row_len, col_a, col_inc;
  logic [ROW_W-1:0] rows, row_a, row_inc;

  assign cfg.ready = 1'b1;

  always_comb begin
    if (width_r == '0) begin
      w_eff = POS_W'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = POS_W'(MAX_WIDTH);
    end else begin
      w_eff = POS_W'(width_r);
    end
    row_len = w_eff + POS_W'(2);
    if (height_r == '0) begin
      rows = ROW_W'(3);
    end else begin
      rows = ROW_W'(height_r) + ROW_W'(2);
    end

    // wrap first if a smaller size left the counters past the end
    col_a = col_r;
    row_a = row_r;
    if (col_r >= row_len) begin
      col_a = '0;
      row_a = row_r + ROW_W'(1);
    end
    if (row_a >= rows) begin
      row_a = '0;
    end

    pos.addr    = col_a[ADDR_W-1:0];
    pos.produce = (row_a >= ROW_W'(2)) && (col_a >= POS_W'(2));
    pos.last    = (row_a == rows - ROW_W'(1)) && (col_a == row_len - POS_W'(1));

    col_inc = col_a + POS_W'(1);
    row_inc = row_a + ROW_W'(1);
    if (col_inc >= row_len) begin
      col_nxt = '0;
      row_nxt = (row_inc >= rows) ? '0 : row_inc;
    end else begin
      col_nxt = col_inc;
      row_nxt = row_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_IMAGE_WIDTH:  width_r  <= cfg.data[WIDTH_REG_W-1:0];
          REG_IMAGE_HEIGHT: height_r <= cfg.data[HEIGHT_REG_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

endmodule

@@ design/gbr_filter.sv @@
// ----------------------------------------------------------------------------
// gbr_filter
// Filter stage: joins line RAM read data with the shift window, writes the
// rows back, forms the weighted 3x3 sum and holds the output register.
// ----------------------------------------------------------------------------
module gbr_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_acc,
  output logic                           in_ready,
  input  gbr_pkg::pos_t                  pos,
  input  gbr_pkg::pix_t                  cur,
  input  logic [2*gbr_pkg::PIX_W-1:0]    ram_rdata,
  output gbr_pkg::ram_wr_t               ram_wr,
  gbr_pix_out_if.source                  out
);
  import gbr_pkg::*;
  `include "assert_macros.svh"

  logic s1_valid_r;
  pos_t s1_pos_r;
  pix_t s1_cur_r;
  pix_t win_r [WIN_TAPS];
  logic s1_adv;
  pix_t up, mid, res;
  logic [SUM_W-1:0] corner, edges, centre, total;

  logic out_valid_r;
  pix_t out_pix_r;
  logic out_last_r;

  assign up  = ram_rdata[2*PIX_W-1:PIX_W];
  assign mid = ram_rdata[PIX_W-1:0];

  // halo words never wait on the output register
  assign s1_adv   = s1_valid_r && (!s1_pos_r.produce || !out_valid_r || out.ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    res    = '0;
    corner = '0;
    edges  = '0;
    centre = '0;
    total  = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      corner = SUM_W'(win_r[0][c]) + SUM_W'(up[c]) + SUM_W'(win_r[2][c])
             + SUM_W'(s1_cur_r[c]);
      edges  = SUM_W'(win_r[3][c]) + SUM_W'(win_r[5][c]) + SUM_W'(win_r[1][c])
             + SUM_W'(mid[c]);
      centre = SUM_W'(win_r[4][c]);
      total  = corner + (edges << 1) + (centre << 2);
      res[c] = CHAN_W'(total >> 4);
    end
  end

  assign ram_wr.we   = s1_adv;
  assign ram_wr.addr = s1_pos_r.addr;
  assign ram_wr.data = {mid, s1_cur_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv && s1_pos_r.produce) begin
        out_valid_r <= 1'b1;
      end else if (out.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pos_r <= pos;
      s1_cur_r <= cur;
    end
    if (s1_adv) begin
      // advance the window by one column
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= up;
      win_r[4] <= mid;
      win_r[5] <= s1_cur_r;
      if (s1_pos_r.produce) begin
        out_pix_r  <= res;
        out_last_r <= s1_pos_r.last;
      end
    end
  end

  assign out.valid      = out_valid_r;
  assign out.out_red    = out_pix_r[0];
  assign out.out_green  = out_pix_r[1];
  assign out.out_blue   = out_pix_r[2];
  assign out.out_alpha  = out_pix_r[3];
  assign out.frame_last = out_last_r;

  `ASSERT_CLK(a_last_is_interior, (s1_valid_r && s1_pos_r.last) |-> s1_pos_r.produce,
              "frame end tagged on a halo word")
  `ASSERT_CLK(a_stall_holds_word,
              (s1_valid_r && s1_pos_r.produce && out_valid_r && !out.ready)
              |=> (s1_valid_r && $stable(s1_cur_r) && $stable(s1_pos_r)),
              "filter stage word lost while output stalled")

endmodule

@@ design/gaussian_blur_3x3_rgba.sv @@
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_rgba
// 3x3 Gaussian blur (1-2-1 / 2-4-2 / 1-2-1, divide by 16) over RGBA words.
// ----------------------------------------------------------------------------
// Feed the halo-padded image, (width+2) x (height+2) words, in raster order
// on in_pix; one blurred interior pixel leaves on out_pix for every word
// whose padded row and column are both at least two, frame_last marking the
// last one of a frame. Halo words are absorbed and give nothing.
// Program image_width (index 0) and image_height (index 1) on cfg_wr while
// the block is empty; cfg_wr.ready is always high.
// Words pass the filter stage register, then the output register.
// Throughput: one word per cycle while out_pix is not stalled; the line RAM
// does one read (at accept) and one write-back (from the filter stage) per word.
// The output register decouples the sides: while a result waits, halo words
// and the next word still enter until the filter stage holds a second result.
// Reset clears the counters and valid flags and loads 1024 x 1024; the line
// RAM is not cleared; its reads in padded rows 0 and 1 reach no output.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_rgba (
  input  logic           clk,
  input  logic           rst_n,
  gbr_pix_in_if.sink     in_pix,
  gbr_pix_out_if.source  out_pix,
  gbr_cfg_if.sink        cfg_wr
);
  import gbr_pkg::*;
  `include "assert_macros.svh"

  logic               in_acc;
  logic               in_ready;
  pos_t               pos;
  pix_t               cur;
  ram_wr_t            ram_wr;
  logic [2*PIX_W-1:0] ram_rdata;

  assign in_pix.ready = in_ready;
  assign in_acc       = in_pix.valid && in_ready;

  assign cur[0] = in_pix.in_red   & CHAN_MASK;
  assign cur[1] = in_pix.in_green & CHAN_MASK;
  assign cur[2] = in_pix.in_blue  & CHAN_MASK;
  assign cur[3] = in_pix.in_alpha & CHAN_MASK;

  gbr_pos u_pos (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_wr),
    .in_acc (in_acc),
    .pos    (pos)
  );

  gbr_line_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (PADDED_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .re    (in_acc),
    .raddr (pos.addr),
    .rdata (ram_rdata)
  );

  gbr_filter u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_ready  (in_ready),
    .pos       (pos),
    .cur       (cur),
    .ram_rdata (ram_rdata),
    .ram_wr    (ram_wr),
    .out       (out_pix)
  );

  // consecutive words sit at different columns, so read and write-back
  // never meet on one entry
  `ASSERT_NEVER(a_no_rw_collision, in_acc && ram_wr.we && (pos.addr == ram_wr.addr),
                "line RAM read and write-back hit the same entry")

endmodule
